>>> src/rvu_pkg.sv
// shared types and constants for the refraction vector unit
package rvu_pkg;

  localparam int VEC_W   = 16;
  localparam int IOR_W   = 14;
  localparam int ETA_W   = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IOR_INC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IOR_TR  = 2'd1;

  localparam logic [ETA_W-1:0] ETA_MAX   = 20'hFFFFF;
  localparam logic [ETA_W-1:0] ETA_RESET = 20'h10000;
  localparam logic [IOR_W-1:0] IOR_RESET = 14'd4096;

  localparam logic [36:0] ONE_Q28 = 37'h0010000000;

  typedef struct packed {
    logic signed [VEC_W-1:0] in_x;
    logic signed [VEC_W-1:0] in_y;
    logic signed [VEC_W-1:0] in_z;
    logic signed [VEC_W-1:0] nrm_x;
    logic signed [VEC_W-1:0] nrm_y;
    logic signed [VEC_W-1:0] nrm_z;
  } in_word_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    total_reflection;
  } out_word_t;

  typedef struct packed {
    logic             busy;
    logic [ETA_W-1:0] eta;
  } eta_stat_t;

endpackage

>>> src/rvu_if.sv
// valid/ready channel interfaces for input and result words
interface rvu_in_if;
  logic              valid;
  logic              ready;
  rvu_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rvu_out_if;
  logic               valid;
  logic               ready;
  rvu_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/refraction_vector_unit_core.sv
// refraction vector unit top level: snell refraction pipeline
// One word enters per cycle unless stalled or dividing; the pipeline
// stalls as a whole only while the result register is held by the sink. A
// write to either index register starts a 30-step serial divide of the
// index ratio, and after the write no word is accepted until the divide is done
// (only while the write is loaded when the transmitted index is zero).
// The 15 stages of the square root, one result bit per stage, set most of the
// latency.
module refraction_vector_unit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rvu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rvu_pkg::IOR_W-1:0]      cfg_wdata,
  rvu_in_if.sink                         in,
  rvu_out_if.source                      out
);
  import rvu_pkg::*;

  localparam int NST = 25;
  localparam int SQ0 = 5;

  typedef struct packed {
    in_word_t           w;
    logic signed [19:0] c;
    logic               tir;
  } carry_t;

  eta_stat_t stat;
  logic en;

  rvu_eta_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stat      (stat)
  );

  logic [NST-1:0] vld_r;
  carry_t carry_r [NST-1];

  logic signed [31:0] p_r [3];
  logic signed [39:0] c2_r;
  logic [32:0]        t_r;
  logic [36:0]        s2_r;
  logic [29:0]        sq_rad_r  [16];
  logic [16:0]        sq_rem_r  [16];
  logic [14:0]        sq_root_r [16];
  logic [14:0]        root_r;
  logic signed [40:0] ec_r;
  logic signed [41:0] k_r;
  logic signed [57:0] a_r [3];
  logic signed [36:0] b_r [3];
  out_word_t          out_r;

  logic signed [20:0] eta_s;
  logic signed [33:0] dot;
  logic [28:0]        sin1;
  logic [48:0]        t_prod;
  logic [52:0]        s2_prod;
  logic               tir_nxt;
  logic [28:0]        rad;
  logic [17:0]        sq_rsh   [16];
  logic [17:0]        sq_trial [16];
  logic signed [15:0] v_arr [3];
  logic signed [15:0] n_arr [3];
  logic signed [15:0] fin [3];
  logic signed [57:0] acc [3];
  logic signed [57:0] accr [3];

  assign en       = !vld_r[NST-1] || out.ready;
  assign in.ready = en && !stat.busy;
  assign eta_s    = $signed({1'b0, stat.eta});

  always_comb begin
    v_arr[0] = in.data.in_x;
    v_arr[1] = in.data.in_y;
    v_arr[2] = in.data.in_z;
    n_arr[0] = in.data.nrm_x;
    n_arr[1] = in.data.nrm_y;
    n_arr[2] = in.data.nrm_z;
    dot = 34'(p_r[0]) + 34'(p_r[1]) + 34'(p_r[2]) + 34'sd8192;
    sin1 = (c2_r > 40'sd268435456) ? 29'd0 : (29'h10000000 - c2_r[28:0]);
    t_prod  = 49'(stat.eta) * 49'(sin1);
    s2_prod = 53'(t_r) * 53'(stat.eta);
    tir_nxt = (s2_r >= ONE_Q28);
    rad     = 29'h10000000 - s2_r[28:0];
    sq_rsh[0]   = '0;
    sq_trial[0] = '0;
    for (int j = 1; j < 16; j++) begin
      sq_rsh[j]   = {sq_rem_r[j-1][15:0], sq_rad_r[j-1][29:28]};
      sq_trial[j] = {1'b0, sq_root_r[j-1], 2'b01};
    end
    for (int i = 0; i < 3; i++) begin
      acc[i]  = a_r[i] - (58'(b_r[i]) <<< 14) + 58'sd536870912;
      accr[i] = acc[i] >>> 30;
      if (accr[i] > 58'sd32767) begin
        fin[i] = 16'sh7FFF;
      end else if (accr[i] < -58'sd32768) begin
        fin[i] = -16'sh8000;
      end else begin
        fin[i] = accr[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in.valid && in.ready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0].w   <= in.data;
      carry_r[0].c   <= '0;
      carry_r[0].tir <= 1'b0;
      for (int k = 1; k < NST-1; k++) begin
        carry_r[k].w <= carry_r[k-1].w;
        if (k != 1) carry_r[k].c <= carry_r[k-1].c;
        if (k != SQ0) carry_r[k].tir <= carry_r[k-1].tir;
      end
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= v_arr[i] * n_arr[i];
      end
      carry_r[1].c   <= dot[33:14];
      c2_r           <= 40'(carry_r[1].c) * 40'(carry_r[1].c);
      t_r            <= t_prod[48:16];
      s2_r           <= s2_prod[52:16];
      carry_r[SQ0].tir <= tir_nxt;
      sq_rad_r[0]    <= {1'b0, rad};
      sq_rem_r[0]    <= '0;
      sq_root_r[0]   <= '0;
      for (int j = 1; j < 16; j++) begin
        sq_rad_r[j] <= {sq_rad_r[j-1][27:0], 2'b00};
        if (sq_rsh[j] >= sq_trial[j]) begin
          sq_rem_r[j]  <= 17'(sq_rsh[j] - sq_trial[j]);
          sq_root_r[j] <= {sq_root_r[j-1][13:0], 1'b1};
        end else begin
          sq_rem_r[j]  <= sq_rsh[j][16:0];
          sq_root_r[j] <= {sq_root_r[j-1][13:0], 1'b0};
        end
      end
      ec_r   <= 41'(eta_s) * 41'(carry_r[20].c);
      root_r <= sq_root_r[15];
      k_r    <= 42'(ec_r) - $signed({11'd0, root_r, 16'd0});
      a_r[0] <= 58'(k_r) * 58'(carry_r[22].w.nrm_x);
      a_r[1] <= 58'(k_r) * 58'(carry_r[22].w.nrm_y);
      a_r[2] <= 58'(k_r) * 58'(carry_r[22].w.nrm_z);
      b_r[0] <= 37'(eta_s) * 37'(carry_r[22].w.in_x);
      b_r[1] <= 37'(eta_s) * 37'(carry_r[22].w.in_y);
      b_r[2] <= 37'(eta_s) * 37'(carry_r[22].w.in_z);
      if (carry_r[23].tir) begin
        out_r <= '{out_x: '0, out_y: '0, out_z: '0, total_reflection: 1'b1};
      end else begin
        out_r <= '{out_x: fin[0], out_y: fin[1], out_z: fin[2], total_reflection: 1'b0};
      end
    end
  end

  assign out.valid = vld_r[NST-1];
  assign out.data  = out_r;

endmodule

>>> src/rvu_eta_div.sv
// index ratio register and serial divider producing eta in Q.16
module rvu_eta_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rvu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rvu_pkg::IOR_W-1:0]      cfg_wdata,
  output rvu_pkg::eta_stat_t             stat
);
  import rvu_pkg::*;

  logic [IOR_W-1:0] inc_r, tr_r;
  logic             load_r, busy_r;
  logic [4:0]       cnt_r;
  logic [29:0]      num_r;
  logic [14:0]      rem_r;
  logic [ETA_W-1:0] eta_r;

  logic [14:0] rem_sh;
  logic        qbit;
  logic [14:0] rem_nxt;
  logic [29:0] num_nxt;

  always_comb begin
    rem_sh  = {rem_r[13:0], num_r[29]};
    qbit    = (rem_sh >= {1'b0, tr_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, tr_r}) : rem_sh;
    num_nxt = {num_r[28:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= IOR_RESET;
      tr_r   <= IOR_RESET;
      load_r <= 1'b0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      eta_r  <= ETA_RESET;
    end else if (cfg_we && (cfg_idx == REG_IOR_INC || cfg_idx == REG_IOR_TR)) begin
      if (cfg_idx == REG_IOR_INC) begin
        inc_r <= cfg_wdata;
      end else begin
        tr_r <= cfg_wdata;
      end
      load_r <= 1'b1;
      busy_r <= 1'b0;
    end else if (load_r) begin
      load_r <= 1'b0;
      if (tr_r == '0) begin
        eta_r <= ETA_MAX;
      end else begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd29;
        num_r  <= {inc_r, 16'd0};
        rem_r  <= '0;
      end
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        eta_r  <= (num_nxt[29:20] != '0) ? ETA_MAX : num_nxt[19:0];
      end
    end
  end

  assign stat.busy = load_r | busy_r;
  assign stat.eta  = eta_r;

endmodule
